/* design/ubds_pkg.sv */
// ----------------------------------------------------------------------------
// ubds_pkg
// Shared types and constants for the UART baud divisor select block.
// ----------------------------------------------------------------------------
package ubds_pkg;

  // clock range accepted, in kHz
  localparam int unsigned CLK_KHZ_MAX = 50000;
  localparam int unsigned CLK_KHZ_MIN = 32;

  // oversampling ratio search range and both-edge bound
  localparam int unsigned OSR_FIRST       = 4;
  localparam int unsigned OSR_LAST        = 32;
  localparam int unsigned BOTH_EDGE_LIMIT = 9;

  // error limit is floor(baud / LIM_DIV) * LIM_MUL
  localparam int unsigned LIM_DIV = 100;
  localparam int unsigned LIM_MUL = 3;

  // field widths
  localparam int unsigned KHZ_W    = 16;
  localparam int unsigned BAUD_W   = 24;
  localparam int unsigned OSR_W    = 6;
  localparam int unsigned SBR_W    = 13;
  localparam int unsigned STATUS_W = 2;

  // internal widths: clock in Hz fits 26 bits, baud * ratio fits 30 bits
  localparam int unsigned HZ_W       = 26;
  localparam int unsigned DIVIDEND_W = HZ_W;
  localparam int unsigned DIVISOR_W  = 30;
  localparam int unsigned DIVCNT_W   = $clog2(DIVIDEND_W);
  localparam int unsigned SEL_W      = 24;
  localparam int unsigned LIM_W      = 18;
  localparam int unsigned LIM3_W     = LIM_W + 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_CLOCK = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // request into the shared divider
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  // answer from the shared divider
  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* design/ubds_if.sv */
// ----------------------------------------------------------------------------
// ubds_in_if / ubds_out_if
// Valid/ready channels carrying the request and result items.
// ----------------------------------------------------------------------------
interface ubds_in_if;
  logic                          valid;
  logic                          ready;
  logic [ubds_pkg::KHZ_W-1:0]    clock_khz;
  logic [ubds_pkg::BAUD_W-1:0]   target_baud;

  modport source (output valid, output clock_khz, output target_baud, input ready);
  modport sink   (input valid, input clock_khz, input target_baud, output ready);
endinterface

interface ubds_out_if;
  logic                            valid;
  logic                            ready;
  logic [ubds_pkg::OSR_W-1:0]      osr;
  logic [ubds_pkg::SBR_W-1:0]      sbr;
  logic                            both_edge;
  logic [ubds_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output osr, output sbr, output both_edge, output status,
                  input ready);
  modport sink   (input valid, input osr, input sbr, input both_edge, input status,
                  output ready);
endinterface

/* design/ubds_div.sv */
// ----------------------------------------------------------------------------
// ubds_div
// Restoring divider, one quotient bit per cycle, shared by all divides.
// ----------------------------------------------------------------------------
module ubds_div (
  input  logic               clk,
  input  logic               rst,
  input  ubds_pkg::div_req_t req,
  output ubds_pkg::div_rsp_t rsp
);

  logic                                busy;
  logic                                done;
  logic [ubds_pkg::DIVCNT_W-1:0]       cnt;
  logic [ubds_pkg::DIVIDEND_W-1:0]     quo;
  logic [ubds_pkg::DIVISOR_W-1:0]      rem;
  logic [ubds_pkg::DIVISOR_W-1:0]      dvs;

  logic [ubds_pkg::DIVISOR_W:0]        rem_sh;
  logic [ubds_pkg::DIVISOR_W:0]        rem_sub;
  logic                                ge;

  // one trial subtract per cycle
  always_comb begin
    rem_sh  = {rem, quo[ubds_pkg::DIVIDEND_W-1]};
    ge      = (rem_sh >= {1'b0, dvs});
    rem_sub = rem_sh - {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= ubds_pkg::DIVCNT_W'(ubds_pkg::DIVIDEND_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[ubds_pkg::DIVIDEND_W-2:0], ge};
      rem <= ge ? rem_sub[ubds_pkg::DIVISOR_W-1:0] : rem_sh[ubds_pkg::DIVISOR_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* design/uart_baud_divisor_select_core.sv */
// ----------------------------------------------------------------------------
// uart_baud_divisor_select_core
// Picks the UART oversampling ratio and baud divisor closest to a wanted baud.
// ----------------------------------------------------------------------------
// One request item (clock in kHz, wanted baud) gives one result item. The
// block walks the ratios 4 to 32; for each it divides the clock by baud*ratio,
// and when that divisor is nonzero divides the clock by ratio*divisor to get
// the achieved baud, keeping the closest (later ratio wins a tie). All divides
// run through one restoring divider that retires one quotient bit per cycle,
// so that divider sets the rate of items; the search is skipped when the clock
// is out of range or the baud is zero. A new request is taken only once the
// result is in the output register, and also while it still waits there.
// ----------------------------------------------------------------------------
module uart_baud_divisor_select_core (
  input  logic            clk,
  input  logic            rst,
  ubds_in_if.sink         req,
  ubds_out_if.source      rsp
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_CHECK   = 12'b000000000010,
    S_LIMGO   = 12'b000000000100,
    S_LIMWAIT = 12'b000000001000,
    S_MUL1    = 12'b000000010000,
    S_D1GO    = 12'b000000100000,
    S_D1WAIT  = 12'b000001000000,
    S_MUL2    = 12'b000010000000,
    S_D2GO    = 12'b000100000000,
    S_D2WAIT  = 12'b001000000000,
    S_CMP     = 12'b010000000000,
    S_FINAL   = 12'b100000000000
  } state_t;

  state_t                                state;

  logic [ubds_pkg::KHZ_W-1:0]            khz;
  logic [ubds_pkg::BAUD_W-1:0]           baud;
  logic [ubds_pkg::HZ_W-1:0]             clk_hz;
  logic [ubds_pkg::OSR_W-1:0]            r;
  logic [ubds_pkg::DIVISOR_W-1:0]        den;
  logic [ubds_pkg::SEL_W-1:0]            d;
  logic [ubds_pkg::HZ_W-1:0]             actual;
  logic [ubds_pkg::OSR_W-1:0]            best_r;
  logic [ubds_pkg::SBR_W-1:0]            best_sbr;
  logic [ubds_pkg::HZ_W-1:0]             best_diff;
  logic                                  found;
  logic                                  range_bad;
  logic [ubds_pkg::LIM_W-1:0]            lim;

  logic                                  o_valid;
  logic [ubds_pkg::OSR_W-1:0]            o_osr;
  logic [ubds_pkg::SBR_W-1:0]            o_sbr;
  logic                                  o_be;
  ubds_pkg::status_t                     o_status;

  ubds_pkg::div_req_t                    div_req;
  ubds_pkg::div_rsp_t                    div_rsp;

  logic [ubds_pkg::DIVISOR_W-1:0]        den1_mul;
  logic [ubds_pkg::DIVISOR_W-1:0]        den2_mul;
  logic [ubds_pkg::HZ_W-1:0]             hz_mul;
  logic [ubds_pkg::HZ_W-1:0]             diff;
  logic [ubds_pkg::LIM3_W-1:0]           lim3;
  logic                                  khz_bad;
  logic                                  last_r;
  logic                                  out_free;

  // shared divider
  ubds_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // divider operands by state
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = clk_hz;
    div_req.divisor  = den;
    case (state)
      S_LIMGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = ubds_pkg::DIVIDEND_W'(baud);
        div_req.divisor  = ubds_pkg::DIVISOR_W'(ubds_pkg::LIM_DIV);
      end
      S_D1GO, S_D2GO: begin
        div_req.start = 1'b1;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // products, error and limit
  always_comb begin
    den1_mul = {6'd0, baud} * {24'd0, r};
    den2_mul = {6'd0, d} * {24'd0, r};
    hz_mul   = {10'd0, khz} * ubds_pkg::HZ_W'(1000);
    diff     = (actual > {2'b00, baud}) ? (actual - {2'b00, baud})
                                        : ({2'b00, baud} - actual);
    lim3     = {2'b00, lim} + {1'b0, lim, 1'b0};
    khz_bad  = (khz > ubds_pkg::KHZ_W'(ubds_pkg::CLK_KHZ_MAX)) ||
               (khz < ubds_pkg::KHZ_W'(ubds_pkg::CLK_KHZ_MIN));
    last_r   = (r == ubds_pkg::OSR_W'(ubds_pkg::OSR_LAST));
    out_free = !o_valid || rsp.ready;
  end

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      found <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          found <= 1'b0;
          if (khz_bad || baud == '0) begin
            state <= S_FINAL;
          end else begin
            state <= S_LIMGO;
          end
        end
        S_LIMGO: begin
          state <= S_LIMWAIT;
        end
        S_LIMWAIT: begin
          if (div_rsp.done) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          state <= S_D1GO;
        end
        S_D1GO: begin
          state <= S_D1WAIT;
        end
        S_D1WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient[ubds_pkg::SEL_W-1:0] != '0) begin
              state <= S_MUL2;
            end else if (last_r) begin
              state <= S_FINAL;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL2: begin
          state <= S_D2GO;
        end
        S_D2GO: begin
          state <= S_D2WAIT;
        end
        S_D2WAIT: begin
          if (div_rsp.done) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (!found || diff <= best_diff) begin
            found <= 1'b1;
          end
          state <= last_r ? S_FINAL : S_MUL1;
        end
        S_FINAL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        khz  <= req.clock_khz;
        baud <= req.target_baud;
      end
      S_CHECK: begin
        clk_hz    <= hz_mul;
        range_bad <= khz_bad;
        r         <= ubds_pkg::OSR_W'(ubds_pkg::OSR_FIRST);
      end
      S_LIMWAIT: begin
        lim <= div_rsp.quotient[ubds_pkg::LIM_W-1:0];
      end
      S_MUL1: begin
        den <= den1_mul;
      end
      S_D1WAIT: begin
        d <= div_rsp.quotient[ubds_pkg::SEL_W-1:0];
        if (div_rsp.done && div_rsp.quotient[ubds_pkg::SEL_W-1:0] == '0 && !last_r) begin
          r <= r + 1'b1;
        end
      end
      S_MUL2: begin
        den <= den2_mul;
      end
      S_D2WAIT: begin
        actual <= div_rsp.quotient;
      end
      S_CMP: begin
        if (!found || diff <= best_diff) begin
          best_diff <= diff;
          best_r    <= r;
          best_sbr  <= d[ubds_pkg::SBR_W-1:0];
        end
        if (!last_r) begin
          r <= r + 1'b1;
        end
      end
      default: begin
        r <= r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      if (o_valid && rsp.ready) begin
        o_valid <= 1'b0;
      end
      if (state == S_FINAL && out_free) begin
        o_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINAL && out_free) begin
      if (range_bad) begin
        o_status <= ubds_pkg::ST_CLOCK;
        o_osr    <= '0;
        o_sbr    <= '0;
        o_be     <= 1'b0;
      end else if (!found || !(best_diff < ubds_pkg::HZ_W'(lim3))) begin
        o_status <= ubds_pkg::ST_ERROR;
        o_osr    <= '0;
        o_sbr    <= '0;
        o_be     <= 1'b0;
      end else begin
        o_status <= ubds_pkg::ST_OK;
        o_osr    <= best_r;
        o_sbr    <= best_sbr;
        o_be     <= (best_r < ubds_pkg::OSR_W'(ubds_pkg::BOTH_EDGE_LIMIT));
      end
    end
  end

  // ports
  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = o_valid;
  assign rsp.osr       = o_osr;
  assign rsp.sbr       = o_sbr;
  assign rsp.both_edge = o_be;
  assign rsp.status    = o_status;

endmodule

/* design/ubds_chk.sv */
// ----------------------------------------------------------------------------
// ubds_chk
// Port-level checks on the result channel of the baud divisor select core.
// ----------------------------------------------------------------------------
module ubds_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ubds_pkg::OSR_W-1:0]      osr,
  input logic [ubds_pkg::SBR_W-1:0]      sbr,
  input logic                            both_edge,
  input logic [ubds_pkg::STATUS_W-1:0]   status
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its ratio, divisor and status
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(osr) && $stable(sbr) && $stable(status))
    else $error("result changed while stalled");

  // nothing offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

  // an accepted setting carries a legal ratio and matching edge flag
  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ubds_pkg::ST_OK |->
      osr >= ubds_pkg::OSR_W'(ubds_pkg::OSR_FIRST) &&
      osr <= ubds_pkg::OSR_W'(ubds_pkg::OSR_LAST) &&
      both_edge == (osr < ubds_pkg::OSR_W'(ubds_pkg::BOTH_EDGE_LIMIT)))
    else $error("bad ratio or edge flag on ok result");

  // a failed search reports an all-zero setting
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ubds_pkg::ST_OK |->
      osr == '0 && sbr == '0 && !both_edge)
    else $error("nonzero setting on failed result");

endmodule

bind uart_baud_divisor_select_core ubds_chk u_ubds_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .osr       (rsp.osr),
  .sbr       (rsp.sbr),
  .both_edge (rsp.both_edge),
  .status    (rsp.status)
);

/* verif/ubds_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubds_result_checker
// Watches the request and result channels of the baud divisor select block,
// works out the expected ratio, divisor, both-edge flag and status for every
// accepted request, and compares each accepted result in order.
// ----------------------------------------------------------------------------
module ubds_result_checker (
  input  logic  clk,
  input  logic  rst,
  ubds_in_if    req,
  ubds_out_if   rsp,
  output int    errors,
  output int    waiting,
  output int    n_ok,
  output int    n_clock,
  output int    n_error
);

  typedef struct packed {
    logic [ubds_pkg::OSR_W-1:0] osr;
    logic [ubds_pkg::SBR_W-1:0] sbr;
    logic                       both_edge;
    ubds_pkg::status_t          status;
  } baud_pick_t;

  baud_pick_t pending_picks[$];

  // search the ratios for the divisor closest to the wanted baud
  function automatic baud_pick_t predict_divisor(input logic [ubds_pkg::KHZ_W-1:0] khz,
                                                 input logic [ubds_pkg::BAUD_W-1:0] baud);
    longint unsigned hz;
    longint unsigned b;
    longint unsigned dvs;
    longint unsigned achieved;
    longint unsigned diff;
    longint unsigned best_diff;
    longint unsigned best_dvs;
    int unsigned     r;
    int unsigned     best_r;
    bit              found;
    baud_pick_t      pick;
    pick.osr       = '0;
    pick.sbr       = '0;
    pick.both_edge = 1'b0;
    pick.status    = ubds_pkg::ST_CLOCK;
    if (khz > ubds_pkg::CLK_KHZ_MAX || khz < ubds_pkg::CLK_KHZ_MIN) return pick;
    hz        = longint'(khz) * 1000;
    b         = longint'(baud);
    found     = 1'b0;
    best_diff = 0;
    best_dvs  = 0;
    best_r    = 0;
    if (b != 0) begin
      for (r = ubds_pkg::OSR_FIRST; r <= ubds_pkg::OSR_LAST; r++) begin
        dvs = hz / (b * r);
        // zero divisor takes no part in the search
        if (dvs != 0) begin
          achieved = hz / (r * dvs);
          diff     = (achieved > b) ? achieved - b : b - achieved;
          // later ratio wins a tie
          if (!found || diff <= best_diff) begin
            found     = 1'b1;
            best_diff = diff;
            best_r    = r;
            best_dvs  = dvs;
          end
        end
      end
    end
    pick.status = ubds_pkg::ST_ERROR;
    if (!found || best_diff >= (b / ubds_pkg::LIM_DIV) * ubds_pkg::LIM_MUL) return pick;
    pick.osr       = best_r[ubds_pkg::OSR_W-1:0];
    pick.sbr       = best_dvs[ubds_pkg::SBR_W-1:0];
    pick.both_edge = (best_r < ubds_pkg::BOTH_EDGE_LIMIT);
    pick.status    = ubds_pkg::ST_OK;
    return pick;
  endfunction

  // one line per mismatch, counted
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors  = 0;
    waiting = 0;
    n_ok    = 0;
    n_clock = 0;
    n_error = 0;
  end

  // predict on every accepted request, compare on every accepted result
  always @(posedge clk) begin : watch
    baud_pick_t want;
    if (!rst) begin
      if (req.valid && req.ready)
        pending_picks.push_back(predict_divisor(req.clock_khz, req.target_baud));
      if (rsp.valid && rsp.ready) begin
        if (pending_picks.size() == 0) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          want = pending_picks.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.osr !== want.osr)
            report_mismatch("osr", rsp.osr, want.osr);
          if (rsp.sbr !== want.sbr)
            report_mismatch("sbr", rsp.sbr, want.sbr);
          if (rsp.both_edge !== want.both_edge)
            report_mismatch("both_edge", rsp.both_edge, want.both_edge);
          case (want.status)
            ubds_pkg::ST_OK:    n_ok++;
            ubds_pkg::ST_CLOCK: n_clock++;
            default:            n_error++;
          endcase
        end
      end
    end
    waiting <= pending_picks.size();
  end

endmodule

/* verif/uart_baud_divisor_select_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_select_core_tb
// Drives clock/baud requests into the divisor select block under several
// handshake idle patterns and a long result back-pressure; the checker beside
// the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module uart_baud_divisor_select_core_tb;

  localparam int CYCLE_LIMIT  = 4000000;
  localparam int HOLD_CYCLES  = 6000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 70;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   stall_pct;
  logic hold_go;
  logic hold_on;
  int   cycle_cnt;
  int   sent;
  int   errors;
  int   waiting;
  int   n_ok;
  int   n_clock;
  int   n_error;

  ubds_in_if  req_ch ();
  ubds_out_if rsp_ch ();

  uart_baud_divisor_select_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ubds_result_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .waiting (waiting),
    .n_ok    (n_ok),
    .n_clock (n_clock),
    .n_error (n_error)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", waiting);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // long result hold-off, counted here while the sender keeps offering
  initial begin
    hold_on <= 1'b0;
    do @(posedge clk); while (!hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // result side ready with random stalls
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= !hold_on && ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // offer one request item, with random idle cycles ahead of it
  task automatic send_request(input logic [ubds_pkg::KHZ_W-1:0] khz,
                              input logic [ubds_pkg::BAUD_W-1:0] baud);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.clock_khz   <= khz;
    req_ch.target_baud <= baud;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  // mostly sane clock/baud pairs, some out of range, some pure noise
  task automatic make_request(output logic [ubds_pkg::KHZ_W-1:0] khz,
                              output logic [ubds_pkg::BAUD_W-1:0] baud);
    int unsigned pick;
    int unsigned top_baud;
    pick = $urandom_range(99, 0);
    if (pick < 8) begin
      khz  = $urandom_range(1, 0)
             ? ubds_pkg::KHZ_W'($urandom_range(ubds_pkg::CLK_KHZ_MIN - 1, 0))
             : ubds_pkg::KHZ_W'($urandom_range(65535, ubds_pkg::CLK_KHZ_MAX + 1));
      baud = ubds_pkg::BAUD_W'($urandom);
    end else if (pick < 16) begin
      khz  = ubds_pkg::KHZ_W'($urandom);
      baud = ubds_pkg::BAUD_W'($urandom);
    end else if (pick < 22) begin
      // zero baud or a baud whose error limit is zero
      khz  = ubds_pkg::KHZ_W'($urandom_range(ubds_pkg::CLK_KHZ_MAX, ubds_pkg::CLK_KHZ_MIN));
      baud = $urandom_range(1, 0) ? '0
             : ubds_pkg::BAUD_W'($urandom_range(ubds_pkg::LIM_DIV - 1, 1));
    end else begin
      if ($urandom_range(3, 0) == 0) begin
        case ($urandom_range(3, 0))
          0:       khz = 16'd48000;
          1:       khz = 16'd24000;
          2:       khz = 16'd20971;
          default: khz = 16'd8000;
        endcase
      end else begin
        khz = ubds_pkg::KHZ_W'($urandom_range(ubds_pkg::CLK_KHZ_MAX, ubds_pkg::CLK_KHZ_MIN));
      end
      if ($urandom_range(1, 0)) begin
        case ($urandom_range(11, 0))
          0:       baud = 24'd300;
          1:       baud = 24'd1200;
          2:       baud = 24'd2400;
          3:       baud = 24'd4800;
          4:       baud = 24'd9600;
          5:       baud = 24'd19200;
          6:       baud = 24'd38400;
          7:       baud = 24'd57600;
          8:       baud = 24'd115200;
          9:       baud = 24'd230400;
          10:      baud = 24'd460800;
          default: baud = 24'd921600;
        endcase
      end else begin
        // spread over octaves at or below clock / 4
        top_baud = (int'(khz) * 1000) / ubds_pkg::OSR_FIRST;
        baud     = ubds_pkg::BAUD_W'($urandom_range(top_baud, 1) >> $urandom_range(16, 0));
        if (baud == 0) baud = 24'd1;
      end
    end
  endtask

  // random part under one idle pattern
  task automatic run_phase(input int send_pct, input int stall, input int items);
    logic [ubds_pkg::KHZ_W-1:0]  khz;
    logic [ubds_pkg::BAUD_W-1:0] baud;
    send_idle_pct = send_pct;
    stall_pct    <= stall;
    repeat (items) begin
      make_request(khz, baud);
      send_request(khz, baud);
    end
  endtask

  initial begin
    sent               = 0;
    send_idle_pct      = 0;
    stall_pct          <= 0;
    hold_go            <= 1'b0;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.clock_khz   <= '0;
    req_ch.target_baud <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: clock range edges, zero baud, skipped ratios, wide divisor
    send_request(16'd0,     24'd9600);
    send_request(16'd31,    24'd9600);
    send_request(16'd32,    24'd9600);
    send_request(16'd32,    24'd300);
    send_request(16'd50000, 24'd115200);
    send_request(16'd50001, 24'd115200);
    send_request(16'd65535, 24'hFFFFFF);
    send_request(16'd48000, 24'd0);
    send_request(16'd65535, 24'd0);
    send_request(16'd48000, 24'd1);
    send_request(16'd48000, 24'd50);
    send_request(16'd50000, 24'd150);
    send_request(16'd50000, 24'd300);
    send_request(16'd50000, 24'd12500000);
    send_request(16'd50000, 24'hFFFFFF);
    send_request(16'd48000, 24'h800000);
    send_request(16'd24000, 24'd921600);
    send_request(16'd20000, 24'd115200);
    send_request(16'd12345, 24'd2500);
    send_request(16'd1,     24'hFFFFFF);

    // random phases
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(80, 0, PHASE_ITEMS);
    run_phase(0, 80, PHASE_ITEMS);
    run_phase(9, 9, PHASE_ITEMS);

    // back-pressure: results held off, requests keep coming
    hold_go <= 1'b1;
    run_phase(0, 0, 8);
    req_ch.valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent in %0d cycles", sent, cycle_cnt);
    $display("results: %0d ok, %0d clock out of range, %0d error too large",
             n_ok, n_clock, n_error);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
